FILE: rtl/tpp_pkg.sv
// Shared constants, codes and types of the trapezoidal position profile.
package tpp_pkg;

   // Fixed point format of positions, limits and times.
   localparam int FRAC_BITS = 16;

   // Field widths.
   localparam int POS_W  = 32;
   localparam int LIM_W  = 31;
   localparam int TIME_W = 32;
   localparam int DIST_W = 32;

   // Internal phase times and whole duration.
   localparam int T_W   = TIME_W + FRAC_BITS;
   localparam int DUR_W = T_W + 1;

   // Shared divider and square root unit.
   localparam int NUM_W = 64;
   localparam int DEN_W = LIM_W + 1;
   localparam int CNT_W = 6;
   localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(NUM_W - 1);
   localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(NUM_W / 2 - 1);

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_POS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_POS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VEL   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ACC   = 2'd3;

   // Profile set-up sequencer states.
   typedef enum logic [3:0] {
      PS_IDLE,
      PS_START,
      PS_MUL,
      PS_CMP,
      PS_SQRT,
      PS_DIV1,
      PS_DIV2,
      PS_SQR,
      PS_DIV3,
      PS_DONE
   } prof_state_type;

   // Motion phase of a query.
   typedef enum logic [1:0] {
      PH_ACCEL,
      PH_CRUISE,
      PH_DECEL
   } phase_type;

   // Controls from the sequencer to its datapath.
   typedef struct packed {
      logic busy;
   } seq_ctl_type;

endpackage

FILE: rtl/trapezoidal_position_profile.sv
// Trapezoidal position profile: set-up sequencer and six-stage query pipeline.
// An accepted query beat moves through the stages in order; the result register offers it.
// Throughput: one query per cycle; the pipeline advances unless the result is stalled.
// A configuration write starts a set-up pass (one sqrt digit or one quotient bit per
// cycle) during which no query is accepted.
// Reset is synchronous: registers take their reset values, the pipeline empties and the
// profile constants match the reset configuration, so no set-up pass follows reset.
module trapezoidal_position_profile (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [tpp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                    csr_wdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,   // [31:0] time_point
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [63:0]                    rsp_tdata    // [31:0] position, [63:32] total_duration
);
   import tpp_pkg::*;

   // Configuration registers.
   logic signed [POS_W-1:0] start_pos_ff;
   logic signed [POS_W-1:0] goal_pos_ff;
   logic [LIM_W-1:0]        max_vel_ff;
   logic [LIM_W-1:0]        max_acc_ff;

   // Profile constants.
   logic [LIM_W-1:0]        v_ff;
   logic [LIM_W-1:0]        a_ff;
   logic                    neg_ff;
   logic [DIST_W-1:0]       d_ff;
   logic [62:0]             da_ff;
   logic [61:0]             vv_ff;
   logic                    tri_ff;
   logic [LIM_W-1:0]        vp_ff;
   logic [T_W-1:0]          t1_ff;
   logic [T_W-1:0]          t2_ff;
   logic [DUR_W-1:0]        dur_ff;
   logic [61:0]             dm_ff;

   // Shared iterative unit.
   logic [NUM_W-1:0]        div_num_ff;
   logic [DEN_W-1:0]        div_rem_ff;
   logic [DEN_W-1:0]        div_den_ff;
   logic [NUM_W-1:0]        sq_n_ff;
   logic [NUM_W-1:0]        sq_res_ff;
   logic [NUM_W-1:0]        sq_bit_ff;
   logic [CNT_W-1:0]        cnt_ff;

   prof_state_type          state_ff;
   prof_state_type          state_in;
   seq_ctl_type             ctl;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_pos_ff <= '0;
         goal_pos_ff  <= '0;
         max_vel_ff   <= LIM_W'(1 << FRAC_BITS);
         max_acc_ff   <= LIM_W'(1 << FRAC_BITS);
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_POS: start_pos_ff <= csr_wdata;
            CSR_GOAL_POS:  goal_pos_ff  <= csr_wdata;
            CSR_MAX_VEL:   max_vel_ff   <= csr_wdata[LIM_W-1:0];
            CSR_MAX_ACC:   max_acc_ff   <= csr_wdata[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer next state; any write restarts the set-up pass.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         PS_IDLE:  state_in = PS_IDLE;
         PS_START: state_in = PS_MUL;
         PS_MUL:   state_in = PS_CMP;
         PS_CMP:   state_in = PS_SQRT;
         PS_SQRT:  if (cnt_ff == SQRT_LAST) state_in = PS_DIV1;
         PS_DIV1:  if (cnt_ff == DIV_LAST) state_in = PS_DIV2;
         PS_DIV2:  if (cnt_ff == DIV_LAST) state_in = PS_SQR;
         PS_SQR:   state_in = PS_DIV3;
         PS_DIV3:  if (cnt_ff == DIV_LAST) state_in = PS_DONE;
         PS_DONE:  state_in = PS_IDLE;
         default:  state_in = PS_IDLE;
      endcase
      if (csr_we) begin
         state_in = PS_START;
      end
   end

   // Sequencer outputs.
   always_comb begin
      ctl = '0;
      case (state_ff)
         PS_IDLE: ;
         default: ctl.busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // One quotient bit of the restoring divider.
   logic [DEN_W:0]     rem_sh;
   logic               div_ge;
   logic [DEN_W-1:0]   rem_nxt;
   logic [NUM_W-1:0]   quo_nxt;
   assign rem_sh  = {div_rem_ff, div_num_ff[NUM_W-1]};
   assign div_ge  = rem_sh >= {1'b0, div_den_ff};
   assign rem_nxt = div_ge ? DEN_W'(rem_sh - {1'b0, div_den_ff}) : rem_sh[DEN_W-1:0];
   assign quo_nxt = {div_num_ff[NUM_W-2:0], div_ge};

   // One digit of the square root.
   logic [NUM_W-1:0]   sq_trial;
   logic               sq_ge;
   logic [NUM_W-1:0]   sq_res_nxt;
   logic [LIM_W-1:0]   vp_sel;
   assign sq_trial   = sq_res_ff + sq_bit_ff;
   assign sq_ge      = sq_n_ff >= sq_trial;
   assign sq_res_nxt = sq_ge ? (sq_res_ff >> 1) + sq_bit_ff : sq_res_ff >> 1;
   // Under the triangle test the root never exceeds the velocity limit.
   assign vp_sel     = tri_ff ? sq_res_nxt[LIM_W-1:0] : v_ff;

   logic signed [POS_W:0] delta;
   assign delta = {goal_pos_ff[POS_W-1], goal_pos_ff} - {start_pos_ff[POS_W-1], start_pos_ff};

   // Set-up datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff   <= LIM_W'(1 << FRAC_BITS);
         a_ff   <= LIM_W'(1 << FRAC_BITS);
         neg_ff <= 1'b0;
         d_ff   <= '0;
         tri_ff <= 1'b1;
         vp_ff  <= '0;
         t1_ff  <= '0;
         t2_ff  <= '0;
         dur_ff <= '0;
         dm_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         case (state_ff)
            PS_START: begin
               v_ff   <= (max_vel_ff == '0) ? LIM_W'(1) : max_vel_ff;
               a_ff   <= (max_acc_ff == '0) ? LIM_W'(1) : max_acc_ff;
               neg_ff <= delta[POS_W];
               d_ff   <= delta[POS_W] ? DIST_W'(-delta) : delta[DIST_W-1:0];
            end
            PS_MUL: begin
               da_ff <= d_ff * a_ff;
               vv_ff <= v_ff * v_ff;
            end
            PS_CMP: begin
               tri_ff    <= {1'b0, da_ff} <= {1'b0, vv_ff};
               sq_n_ff   <= {1'b0, da_ff};
               sq_res_ff <= '0;
               sq_bit_ff <= NUM_W'(1) << (NUM_W - 2);
               cnt_ff    <= '0;
            end
            PS_SQRT: begin
               if (sq_ge) begin
                  sq_n_ff <= sq_n_ff - sq_trial;
               end
               sq_res_ff <= sq_res_nxt;
               sq_bit_ff <= sq_bit_ff >> 2;
               if (cnt_ff == SQRT_LAST) begin
                  vp_ff      <= vp_sel;
                  div_num_ff <= NUM_W'(vp_sel) << FRAC_BITS;
                  div_den_ff <= DEN_W'(a_ff);
                  div_rem_ff <= '0;
                  cnt_ff     <= '0;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            PS_DIV1: begin
               if (cnt_ff == DIV_LAST) begin
                  t1_ff      <= quo_nxt[T_W-1:0];
                  div_num_ff <= NUM_W'(d_ff) << FRAC_BITS;
                  div_den_ff <= DEN_W'(v_ff);
                  div_rem_ff <= '0;
                  cnt_ff     <= '0;
               end else begin
                  div_num_ff <= quo_nxt;
                  div_rem_ff <= rem_nxt;
                  cnt_ff     <= cnt_ff + 1'b1;
               end
            end
            PS_DIV2: begin
               div_num_ff <= quo_nxt;
               div_rem_ff <= rem_nxt;
               cnt_ff     <= cnt_ff + 1'b1;
               if (cnt_ff == DIV_LAST) begin
                  t2_ff <= tri_ff ? t1_ff : quo_nxt[T_W-1:0];
               end
            end
            PS_SQR: begin
               div_num_ff <= NUM_W'(vp_ff) * NUM_W'(vp_ff);
               div_den_ff <= {a_ff, 1'b0};
               div_rem_ff <= '0;
               cnt_ff     <= '0;
            end
            PS_DIV3: begin
               div_num_ff <= quo_nxt;
               div_rem_ff <= rem_nxt;
               cnt_ff     <= cnt_ff + 1'b1;
               if (cnt_ff == DIV_LAST) begin
                  dm_ff <= quo_nxt[61:0];
               end
            end
            PS_DONE: dur_ff <= {1'b0, t1_ff} + {1'b0, t2_ff};
            default: ;
         endcase
      end
   end

   // Query pipeline: every stage moves when the result register is free or taken.
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en && !ctl.busy;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;

   // Stage 1: clamp the time to the duration.
   logic [TIME_W-1:0] s1_tc_ff;
   // Stage 2: phase, square argument and cruise offset.
   phase_type         s2_ph_ff;
   logic              s2_big_ff;
   logic [TIME_W-1:0] s2_x_ff;
   logic [TIME_W-1:0] s2_dt_ff;
   // Stage 3: first products.
   phase_type         s3_ph_ff;
   logic              s3_big_ff;
   logic [TIME_W-1:0] s3_x_ff;
   logic [62:0]       s3_m1_ff;
   logic [62:0]       s3_m2_ff;
   // Stage 4: partial products of the square and the cruise distance.
   phase_type         s4_ph_ff;
   logic              s4_big_ff;
   logic [63:0]       s4_pl_ff;
   logic [62:0]       s4_ph_prod_ff;
   logic [63:0]       s4_cr_ff;
   // Stage 5: travelled distance.
   logic [DIST_W-1:0] s5_dist_ff;
   // Stage 6: result register.
   logic [POS_W-1:0]  s6_pos_ff;
   logic [31:0]       s6_dur_ff;

   logic [DUR_W-1:0]  tc_ext;
   logic [DUR_W-1:0]  x_full;
   logic              in_accel;
   logic              in_cruise;
   logic [94:0]       sq_full;
   logic [94:0]       sq_q;
   logic              q_gt_d;
   logic              q_ge_d;
   logic              cr_gt_d;
   logic [DIST_W-1:0] dist_sel;

   assign tc_ext    = DUR_W'(s1_tc_ff);
   assign in_accel  = tc_ext < {1'b0, t1_ff};
   assign in_cruise = tc_ext < {1'b0, t2_ff};
   assign x_full    = in_accel ? tc_ext : dur_ff - tc_ext;

   assign sq_full = {s4_ph_prod_ff, 32'b0} + 95'(s4_pl_ff);
   assign sq_q    = sq_full >> (FRAC_BITS + 1);
   assign q_gt_d  = sq_q > 95'(d_ff);
   assign q_ge_d  = sq_q >= 95'(d_ff);
   assign cr_gt_d = s4_cr_ff > 64'(d_ff);

   // Distance by phase, kept between zero and the full distance.
   always_comb begin
      case (s4_ph_ff)
         PH_ACCEL:  dist_sel = (s4_big_ff || q_gt_d) ? d_ff : sq_q[DIST_W-1:0];
         PH_CRUISE: dist_sel = cr_gt_d ? d_ff : s4_cr_ff[DIST_W-1:0];
         PH_DECEL:  dist_sel = (s4_big_ff || q_ge_d) ? '0 : d_ff - sq_q[DIST_W-1:0];
         default:   dist_sel = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid && req_tready;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_tc_ff <= ({{(DUR_W-TIME_W){1'b0}}, req_tdata} > dur_ff) ?
                     dur_ff[TIME_W-1:0] : req_tdata;

         s2_ph_ff  <= in_accel ? PH_ACCEL : (in_cruise ? PH_CRUISE : PH_DECEL);
         s2_big_ff <= |x_full[DUR_W-1:TIME_W];
         s2_x_ff   <= x_full[TIME_W-1:0];
         s2_dt_ff  <= s1_tc_ff - t1_ff[TIME_W-1:0];

         s3_ph_ff  <= s2_ph_ff;
         s3_big_ff <= s2_big_ff;
         s3_x_ff   <= s2_x_ff;
         s3_m1_ff  <= a_ff * s2_x_ff;
         s3_m2_ff  <= vp_ff * s2_dt_ff;

         s4_ph_ff      <= s3_ph_ff;
         s4_big_ff     <= s3_big_ff;
         s4_pl_ff      <= s3_m1_ff[31:0] * s3_x_ff;
         s4_ph_prod_ff <= s3_m1_ff[62:32] * s3_x_ff;
         s4_cr_ff      <= 64'(dm_ff) + 64'(s3_m2_ff >> FRAC_BITS);

         s5_dist_ff <= dist_sel;

         s6_pos_ff <= neg_ff ? start_pos_ff - s5_dist_ff : start_pos_ff + s5_dist_ff;
         s6_dur_ff <= (|dur_ff[DUR_W-1:32]) ? 32'hFFFF_FFFF : dur_ff[31:0];
      end
   end

   assign rsp_tvalid = v6_ff;
   assign rsp_tdata  = {s6_dur_ff, s6_pos_ff};

`ifndef SYNTH
   // A configuration write holds off queries until the set-up pass ends.
   a_csr_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_tready)
      else $error("query accepted straight after a configuration write");

   // A triangular profile has no cruise phase: its phase boundaries t1 and t2 are equal.
   a_tri_sym: assert property (@(posedge clock) disable iff (reset)
      (state_ff == PS_IDLE) && tri_ff |-> t1_ff == t2_ff)
      else $error("triangular profile with unequal phase times");

   // The root unit runs for half as many steps as the dividend has bits.
   a_sqrt_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == PS_SQRT) |-> cnt_ff <= SQRT_LAST)
      else $error("square root step count overrun");

   // The duration is the sum of the two phase times once set-up has ended.
   a_dur_sum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == PS_IDLE) && $past(state_ff == PS_DONE) |->
         dur_ff == {1'b0, t1_ff} + {1'b0, t2_ff})
      else $error("duration differs from the phase times");
`endif

endmodule

FILE: bench/tb_trapezoidal_position_profile.sv
// Self-checking testbench of the trapezoidal position profile block.
`timescale 1ns / 100ps

module tb_trapezoidal_position_profile;
   import tpp_pkg::*;

   localparam longint unsigned U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

   // One expected result beat.
   typedef struct {
      logic [31:0] position;
      logic [31:0] total_duration;
   } sample_type;

   // Holds the profile settings and the positions still to come.
   class profile_scoreboard;
      longint          start_pos;
      longint          goal_pos;
      longint unsigned max_vel;
      longint unsigned max_acc;
      sample_type      expected_q[$];

      function new();
         start_pos = 0;
         goal_pos  = 0;
         max_vel   = 64'd1 << FRAC_BITS;
         max_acc   = 64'd1 << FRAC_BITS;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
         case (idx)
            CSR_START_POS: start_pos = longint'(signed'(value));
            CSR_GOAL_POS:  goal_pos  = longint'(signed'(value));
            CSR_MAX_VEL:   max_vel   = {33'd0, value[30:0]};
            CSR_MAX_ACC:   max_acc   = {33'd0, value[30:0]};
            default: ;
         endcase
      endfunction

      // Floor of x*y over 2^(FRAC_BITS+1), saturated to 64 bits.
      function longint unsigned half_square(longint unsigned x, longint unsigned y);
         logic [127:0] prod;
         prod = {64'd0, x} * {64'd0, y};
         prod = prod >> (FRAC_BITS + 1);
         if (prod[127:64] != 0)
            return U64_MAX;
         return prod[63:0];
      endfunction

      function longint unsigned int_sqrt(longint unsigned n);
         longint unsigned res, bitv;
         res  = 0;
         bitv = 64'd1 << 62;
         while (bitv > n)
            bitv = bitv >> 2;
         while (bitv != 0) begin
            if (n >= res + bitv) begin
               n   = n - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      // Phase boundaries of the current move, with distance and peak velocity.
      function void phase_times(output longint unsigned dist_total, output bit neg,
                                output longint unsigned peak, output longint unsigned t1,
                                output longint unsigned t2, output longint unsigned dur);
         longint unsigned v, a;
         longint          delta;
         v     = (max_vel == 0) ? 1 : max_vel;
         a     = (max_acc == 0) ? 1 : max_acc;
         delta = goal_pos - start_pos;
         neg   = delta < 0;
         dist_total = neg ? longint'(-delta) : delta;
         if (dist_total * a <= v * v) begin
            peak = int_sqrt(dist_total * a);
            t1   = (peak << FRAC_BITS) / a;
            t2   = t1;
         end else begin
            peak = v;
            t1   = (peak << FRAC_BITS) / a;
            t2   = (dist_total << FRAC_BITS) / v;
         end
         dur = t1 + t2;
      endfunction

      function sample_type position_at(logic [31:0] time_point);
         longint unsigned d, vp, t1, t2, dur, t, travel, a, r, sub;
         bit              neg;
         longint          pos;
         sample_type      s;
         phase_times(d, neg, vp, t1, t2, dur);
         a = (max_acc == 0) ? 1 : max_acc;
         t = {32'd0, time_point};
         if (t > dur)
            t = dur;
         if (t < t1) begin
            travel = half_square(a * t, t);
         end else if (t < t2) begin
            travel = (vp * vp) / (2 * a) + ((vp * (t - t1)) >> FRAC_BITS);
         end else begin
            r      = dur - t;
            sub    = (r <= t1) ? half_square(a * r, r) : U64_MAX;
            travel = (sub >= d) ? 0 : d - sub;
         end
         if (travel > d)
            travel = d;
         pos = neg ? start_pos - longint'(travel) : start_pos + longint'(travel);
         s.position       = pos[31:0];
         s.total_duration = (dur > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dur[31:0];
         return s;
      endfunction

      function void note_query(logic [31:0] time_point);
         expected_q.push_back(position_at(time_point));
      endfunction

      // Returns an empty string when the beat matches the oldest expectation.
      function string check_result(logic [63:0] data);
         sample_type s;
         string      msg;
         if (expected_q.size() == 0)
            return $sformatf("unexpected result beat %h", data);
         s   = expected_q.pop_front();
         msg = "";
         if (data[31:0] !== s.position)
            msg = $sformatf("position %h, expected %h", data[31:0], s.position);
         if (data[63:32] !== s.total_duration)
            msg = {msg, $sformatf(" total_duration %h, expected %h",
                                  data[63:32], s.total_duration)};
         return msg;
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_wdata;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [31:0]          req_tdata;   // [31:0] time_point
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [63:0]          rsp_tdata;   // [31:0] position, [63:32] total_duration

   profile_scoreboard sb;
   int                error_count;
   bit                long_hold;

   trapezoidal_position_profile u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run limit.
   initial begin
      #20ms;
      $display("tb_trapezoidal_position_profile: done, errors");
      $finish;
   end

   task automatic report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Mostly short gaps, now and then a long one.
   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Accepted query beats feed the scoreboard.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_query(req_tdata);
   end

   // Accepted result beats are checked.
   always @(posedge clock) begin
      string msg;
      if (!reset && rsp_tvalid && rsp_tready) begin
         msg = sb.check_result(rsp_tdata);
         if (msg != "")
            report(msg);
      end
   end

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            long_hold = 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
            gap = random_gap();
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   // Offers one query beat and waits for its handshake; the valid stays up
   // when no gap follows.
   task automatic send_query(logic [31:0] time_point, bit no_gap = 1'b0);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= time_point;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      gap = no_gap ? 0 : random_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops offering and waits until every expected result has come.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Writes one register while the block is idle and waits out its set-up pass.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
      csr_we <= 1'b0;
      repeat (3) @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   task automatic set_profile(logic [31:0] start, logic [31:0] goal,
                              logic [31:0] vel, logic [31:0] acc);
      drain();
      write_reg(CSR_START_POS, start);
      write_reg(CSR_GOAL_POS, goal);
      write_reg(CSR_MAX_VEL, vel);
      write_reg(CSR_MAX_ACC, acc);
   endtask

   // Queries at time zero, the largest time, the phase boundaries of the move and their neighbours.
   task automatic boundary_queries();
      longint unsigned d, vp, t1, t2, dur;
      bit              neg;
      sb.phase_times(d, neg, vp, t1, t2, dur);
      send_query(32'd0);
      send_query(32'hFFFF_FFFF);
      send_query(t1[31:0]);
      send_query(t1[31:0] - 32'd1);
      send_query(t1[31:0] + 32'd1);
      send_query(t2[31:0]);
      send_query(t2[31:0] + 32'd1);
      send_query(dur[31:0] - 32'd1);
      send_query(dur[31:0]);
      send_query(dur[31:0] + 32'd1);
   endtask

   // A random query time, mostly inside the move.
   function automatic logic [31:0] random_time();
      longint unsigned d, vp, t1, t2, dur;
      bit              neg;
      sb.phase_times(d, neg, vp, t1, t2, dur);
      if ($urandom_range(0, 9) < 2 || dur == 0)
         return $urandom();
      if (dur > 64'hFFFF_FFFF)
         dur = 64'hFFFF_FFFF;
      return $urandom_range(0, dur[31:0]);
   endfunction

   // Random profile: positions full range or a short hop, limits of varied size.
   task automatic random_profile();
      logic [31:0] start, goal, vel, acc;
      start = $urandom();
      goal  = ($urandom_range(0, 1) == 0) ? $urandom() : start + $urandom_range(0, 1 << 20)
                                                      - (1 << 19);
      vel   = $urandom() >> $urandom_range(1, 24);
      acc   = $urandom() >> $urandom_range(1, 24);
      set_profile(start, goal, vel, acc);
   endtask

   // Main sequence.
   initial begin
      error_count = 0;
      long_hold   = 1'b0;
      sb          = new();
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset profile: zero distance.
      send_query(32'd0);
      send_query(32'hFFFF_FFFF);

      // Cruise move, then a triangular one, with boundary queries.
      set_profile(32'h0000_0000, 32'h0010_0000, 32'h0001_0000, 32'h0002_0000);
      boundary_queries();
      set_profile(32'h0005_0000, 32'hFFFF_0000, 32'h0010_0000, 32'h0000_8000);
      boundary_queries();

      // Extremes: full span at smallest and zero limits, at the largest, and at zero acceleration.
      set_profile(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd1);
      boundary_queries();
      set_profile(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      boundary_queries();
      set_profile(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
      boundary_queries();

      // Random profiles with random queries.
      for (int p = 0; p < 20; p++) begin
         random_profile();
         boundary_queries();
         for (int i = 0; i < 37; i++)
            send_query(random_time());
         if (p == 5) begin
            // Long receiver hold-off while queries keep coming.
            long_hold = 1'b1;
            for (int i = 0; i < 60; i++)
               send_query(random_time(), 1'b1);
         end
         if (p == 10)
            drain();
      end

      drain();
      if (error_count == 0)
         $display("tb_trapezoidal_position_profile: done, clean");
      else
         $display("tb_trapezoidal_position_profile: done, errors");
      $finish;
   end

endmodule
